[rtl/rap_pkg.sv]
// ----------------------------------------------------------------------------
// rap_pkg
// Shared types and constants of the running autocorrelation peak block.
// ----------------------------------------------------------------------------
`default_nettype none

package rap_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int INDEX_W     = 10;
  localparam int SCORE_W     = 49;
  localparam int ACC_W       = 48;
  localparam int COEF_W      = 16;
  localparam int PROD_W      = ACC_W + COEF_W;
  localparam int DECAY_SHIFT = 16;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;
  localparam int COUNT_W     = 16;

  localparam logic [CFG_DATA_W-1:0]  DECAY_FACTOR_RST = 16'd65470;
  localparam logic [CFG_DATA_W-1:0]  DECAY_PERIOD_RST = 16'd500;

  localparam logic [CFG_INDEX_W-1:0] REG_DECAY_FACTOR = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DECAY_PERIOD = 8'd1;

  typedef enum logic [1:0] {
    OP_ACC,
    OP_SEARCH,
    OP_DECAY
  } rap_op_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                block_end;
  } rap_in_t;

  typedef struct packed {
    logic [INDEX_W-1:0] peak_index;
    logic [SCORE_W-1:0] peak_score;
  } rap_out_t;

  typedef struct packed {
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  wdata;
  } rap_cfg_t;

  // controller to datapath
  typedef struct packed {
    logic              store;
    logic              start;
    rap_op_t           op;
    logic              load_out;
    logic [COEF_W-1:0] decay_factor;
  } rap_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic idle;
  } rap_sts_t;

endpackage

`default_nettype wire

[rtl/rap_stream_if.sv]
// ----------------------------------------------------------------------------
// rap_stream_if
// Valid/ready channel carrying one item of a chosen type.
// ----------------------------------------------------------------------------
`default_nettype none

interface rap_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/rap_ram.sv]
// ----------------------------------------------------------------------------
// rap_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module rap_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[rtl/rap_ctrl.sv]
// ----------------------------------------------------------------------------
// rap_ctrl
// Sequencer: item handshake, accumulate/search/decay order, block count and
// configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module rap_ctrl
  import rap_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  input  wire logic                   in_block_end,
  output logic                        in_ready,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  input  wire logic                   cfg_valid,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
  output logic                        cfg_ready,
  output rap_cmd_t                    cmd,
  input  wire rap_sts_t               sts
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACC,
    S_SEARCH,
    S_DECAY
  } state_t;

  state_t               state_r,     state_nxt;
  logic                 start_r,     start_nxt;
  rap_op_t              op_r,        op_nxt;
  logic                 last_r,      last_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0]   count_r,     count_nxt;
  logic [COEF_W-1:0]    factor_r,    factor_nxt;
  logic [CFG_DATA_W-1:0] period_r,   period_nxt;

  logic accept;
  logic out_free;
  logic engine_done;
  logic load_out;

  assign accept      = in_valid && (state_r == S_IDLE);
  assign out_free    = !out_valid_r || out_ready;
  assign engine_done = !start_r && sts.idle;

  always_comb begin
    state_nxt     = state_r;
    start_nxt     = 1'b0;
    op_nxt        = op_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    count_nxt     = count_r;
    factor_nxt    = factor_r;
    period_nxt    = period_r;
    load_out      = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          start_nxt = 1'b1;
          op_nxt    = OP_ACC;
          last_nxt  = in_block_end;
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        if (engine_done) begin
          if (last_r) begin
            start_nxt = 1'b1;
            op_nxt    = OP_SEARCH;
            state_nxt = S_SEARCH;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_SEARCH: begin
        // hand the peak to the output register once it is free
        if (engine_done && out_free) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          if (count_r >= period_r) begin
            count_nxt = '0;
            start_nxt = 1'b1;
            op_nxt    = OP_DECAY;
            state_nxt = S_DECAY;
          end else begin
            count_nxt = count_r + 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_DECAY: begin
        if (engine_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_valid) begin
      unique case (cfg_index)
        REG_DECAY_FACTOR: factor_nxt = cfg_wdata;
        REG_DECAY_PERIOD: period_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      op_r        <= OP_ACC;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      factor_r    <= DECAY_FACTOR_RST;
      period_r    <= DECAY_PERIOD_RST;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      op_r        <= op_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      factor_r    <= factor_nxt;
      period_r    <= period_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign cfg_ready = 1'b1;

  assign cmd.store        = accept;
  assign cmd.start        = start_r;
  assign cmd.op           = op_r;
  assign cmd.load_out     = load_out;
  assign cmd.decay_factor = factor_r;

endmodule

`default_nettype wire

[rtl/rap_datapath.sv]
// ----------------------------------------------------------------------------
// rap_datapath
// History ring, accumulator memory and a three-stage sweep pipeline shared by
// accumulate, peak search and decay.
// ----------------------------------------------------------------------------
`default_nettype none

module rap_datapath
  import rap_pkg::*;
#(
  parameter int HISTORY_DEPTH = 4096,
  parameter int MIN_LAG       = 100,
  parameter int ACORR_LENGTH  = 2001,
  parameter int RANGE_SIZE    = 601,
  parameter int SAMPLE_BITS   = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire rap_cmd_t            cmd,
  output rap_sts_t                 sts,
  input  wire logic [SAMPLE_W-1:0] in_sample,
  output logic      [INDEX_W-1:0]  out_peak_index,
  output logic      [SCORE_W-1:0]  out_peak_score
);

  localparam int HW   = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam int AW   = $clog2(HISTORY_DEPTH);
  localparam int FW   = $clog2(HISTORY_DEPTH + 1);
  localparam int AIW  = $clog2(ACORR_LENGTH);
  localparam int MAXC = (ACORR_LENGTH > RANGE_SIZE) ? ACORR_LENGTH : RANGE_SIZE;
  localparam int SW   = $clog2(MAXC + 1);
  localparam int MLD  = MIN_LAG % HISTORY_DEPTH;

  // ring position and fill level
  logic [AW-1:0] wp_r,   wp_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [HW-1:0] sample_r;

  // sweep issue stage
  logic          run_r,   run_nxt;
  rap_op_t       mode_r,  mode_nxt;
  logic [SW-1:0] idx_r,   idx_nxt;
  logic          phase_r, phase_nxt;
  logic [AW-1:0] lag_r,   lag_nxt;
  logic [AW-1:0] hptr_r,  hptr_nxt;
  logic          started_r, acc_valid_r;

  // stage 1 and 2
  logic              p1_v_r, p2_v_r;
  logic [SW-1:0]     p1_idx_r, p2_idx_r;
  logic              p1_hval_r, p1_zero_r, p1_phase_r;
  logic [PROD_W-1:0] prod_r;
  logic [ACC_W-1:0]  accold_r;
  logic [ACC_W-1:0]  a_r;
  logic [SCORE_W-1:0] score_r;
  logic [SCORE_W-1:0] best_r;
  logic [SW-1:0]      best_i_r;
  logic [INDEX_W-1:0] out_index_r;
  logic [SCORE_W-1:0] out_score_r;

  // memory ports
  logic [HW-1:0]    hist_rd;
  logic [ACC_W-1:0] acc_rd;
  logic [AIW-1:0]   acc_raddr;
  logic             acc_we;
  logic [ACC_W-1:0] acc_wdata;

  logic [SW:0]          dbl;
  logic                 s0_zero;
  logic                 s0_last;
  logic [AW-1:0]        hptr_init;
  logic [ACC_W-1:0]     accd;
  logic [HW-1:0]        histd;
  logic [ACC_W-1:0]     mult_a;
  logic [COEF_W-1:0]    mult_b;
  logic [ACC_W-1:0]     opnd_b;
  logic [ACC_W:0]       sum;

  // ---------------------------------------------------------------- ring write
  always_comb begin
    wp_nxt   = wp_r;
    fill_nxt = fill_r;
    if (cmd.store) begin
      wp_nxt = (wp_r == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (fill_r != FW'(HISTORY_DEPTH)) begin
        fill_nxt = fill_r + 1'b1;
      end
    end
  end

  rap_ram #(
    .WIDTH (HW),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (wp_nxt),
    .wdata (in_sample[HW-1:0]),
    .raddr (hptr_r),
    .rdata (hist_rd)
  );

  // ---------------------------------------------------------------- issue stage
  assign dbl       = {idx_r, 1'b0};
  assign hptr_init = (wp_r >= AW'(MLD)) ? wp_r - AW'(MLD)
                                        : AW'(32'(wp_r) + HISTORY_DEPTH - MLD);

  always_comb begin
    acc_raddr = idx_r[AIW-1:0];
    s0_zero   = 1'b0;
    s0_last   = (idx_r == SW'(ACORR_LENGTH - 1));
    if (mode_r == OP_SEARCH) begin
      s0_last = phase_r && (idx_r == SW'(RANGE_SIZE - 1));
      if (phase_r) begin
        acc_raddr = dbl[AIW-1:0];
        s0_zero   = (dbl >= (SW+1)'(ACORR_LENGTH));
      end else begin
        s0_zero   = (idx_r >= SW'(ACORR_LENGTH));
      end
    end
  end

  always_comb begin
    run_nxt   = run_r;
    mode_nxt  = mode_r;
    idx_nxt   = idx_r;
    phase_nxt = phase_r;
    lag_nxt   = lag_r;
    hptr_nxt  = hptr_r;
    if (cmd.start) begin
      run_nxt   = 1'b1;
      mode_nxt  = cmd.op;
      idx_nxt   = '0;
      phase_nxt = 1'b0;
      lag_nxt   = AW'(MLD);
      hptr_nxt  = hptr_init;
    end else if (run_r) begin
      if (s0_last) begin
        run_nxt = 1'b0;
      end
      if (mode_r == OP_SEARCH) begin
        phase_nxt = !phase_r;
        if (phase_r) begin
          idx_nxt = idx_r + 1'b1;
        end
      end else begin
        idx_nxt  = idx_r + 1'b1;
        lag_nxt  = (lag_r == AW'(HISTORY_DEPTH - 1)) ? '0 : lag_r + 1'b1;
        hptr_nxt = (hptr_r == '0) ? AW'(HISTORY_DEPTH - 1) : hptr_r - 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- stage 1
  always_comb begin
    accd   = acc_valid_r ? acc_rd : '0;
    histd  = p1_hval_r ? hist_rd : '0;
    opnd_b = p1_zero_r ? '0 : accd;
    if (mode_r == OP_DECAY) begin
      mult_a = accd;
      mult_b = cmd.decay_factor;
    end else begin
      mult_a = ACC_W'(histd);
      mult_b = COEF_W'(sample_r);
    end
  end

  // ---------------------------------------------------------------- stage 2
  assign sum    = {1'b0, accold_r} + {1'b0, prod_r[ACC_W-1:0]};
  assign acc_we = p2_v_r && (mode_r != OP_SEARCH);

  always_comb begin
    if (mode_r == OP_DECAY) begin
      acc_wdata = prod_r[DECAY_SHIFT +: ACC_W];
    end else begin
      acc_wdata = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
    end
  end

  rap_ram #(
    .WIDTH (ACC_W),
    .DEPTH (ACORR_LENGTH)
  ) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (p2_idx_r[AIW-1:0]),
    .wdata (acc_wdata),
    .raddr (acc_raddr),
    .rdata (acc_rd)
  );

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      fill_r      <= '0;
      run_r       <= 1'b0;
      mode_r      <= OP_ACC;
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      started_r   <= 1'b0;
      acc_valid_r <= 1'b0;
    end else begin
      wp_r   <= wp_nxt;
      fill_r <= fill_nxt;
      run_r  <= run_nxt;
      mode_r <= mode_nxt;
      p1_v_r <= run_r && !cmd.start;
      p2_v_r <= p1_v_r && ((mode_r != OP_SEARCH) || p1_phase_r);
      // accumulators read as zero until the first sweep has written them all
      if (cmd.start) begin
        started_r   <= 1'b1;
        acc_valid_r <= acc_valid_r || started_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    phase_r <= phase_nxt;
    lag_r   <= lag_nxt;
    hptr_r  <= hptr_nxt;
    if (cmd.store) begin
      sample_r <= in_sample[HW-1:0];
    end

    p1_idx_r   <= idx_r;
    p1_hval_r  <= (FW'(lag_r) < fill_r);
    p1_zero_r  <= s0_zero;
    p1_phase_r <= phase_r;

    prod_r   <= mult_a * mult_b;
    accold_r <= accd;
    if (p1_v_r && !p1_phase_r) begin
      a_r <= opnd_b;
    end
    score_r  <= {1'b0, a_r} + {1'b0, opnd_b};
    p2_idx_r <= p1_idx_r;

    if (cmd.start) begin
      best_r   <= '0;
      best_i_r <= '0;
    end else if (p2_v_r && (mode_r == OP_SEARCH) && (score_r > best_r)) begin
      best_r   <= score_r;
      best_i_r <= p2_idx_r;
    end

    if (cmd.load_out) begin
      out_index_r <= INDEX_W'(best_i_r);
      out_score_r <= best_r;
    end
  end

  assign sts.idle       = !run_r && !p1_v_r && !p2_v_r;
  assign out_peak_index = out_index_r;
  assign out_peak_score = out_score_r;

  // ---------------------------------------------------------------- checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(HISTORY_DEPTH))
    else $error("history fill count beyond ring depth");

  a_search_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == OP_SEARCH) |-> !acc_we)
    else $error("accumulator written during peak search");

  a_stage_order: assert property (@(posedge clk) disable iff (!rst_n)
    p2_v_r |-> $past(p1_v_r))
    else $error("stage 2 valid without stage 1 item");

  a_best_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    ((mode_r == OP_SEARCH) && !cmd.start) |=> (best_r >= $past(best_r)))
    else $error("best score decreased during search");

endmodule

`default_nettype wire

[rtl/running_autocorrelation_peak.sv]
// ----------------------------------------------------------------------------
// running_autocorrelation_peak
// Running autocorrelation of an envelope stream with periodic peak search
// and accumulator decay.
// ----------------------------------------------------------------------------
//
//   port    | role   | item fields
//   --------+--------+--------------------------------------------
//   in_if   | sink   | sample[15:0], block_end
//   out_if  | source | peak_index[9:0], peak_score[48:0]
//   cfg_if  | sink   | index[7:0] (0 decay_factor, 1 decay_period), wdata[15:0]
//
// Sweeps: each accepted item starts an accumulate sweep, one lag per cycle
//   through the accumulator RAM, and the next item is accepted only once
//   all sweeps for the last one have ended. With block_end a peak search
//   follows (two reads of the single accumulator read port per index), and
//   a decay sweep follows it on the blocks that decay.
// Reset: clears control state only; the memories need no clearing pass, a
//   fill count guards the history ring and a first-sweep flag the
//   accumulators.
// Stalls: a waiting result sits in the output register while the next items
//   are accepted; only a second search result waits for it to drain.
// ----------------------------------------------------------------------------
`default_nettype none

module running_autocorrelation_peak
  import rap_pkg::*;
#(
  parameter int HISTORY_DEPTH = 4096,
  parameter int MIN_LAG       = 100,
  parameter int ACORR_LENGTH  = 2001,
  parameter int RANGE_SIZE    = 601,
  parameter int SAMPLE_BITS   = 16
) (
  input wire logic   clk,
  input wire logic   rst_n,
  rap_stream_if.sink   in_if,
  rap_stream_if.source out_if,
  rap_stream_if.sink   cfg_if
);

  rap_cmd_t cmd;
  rap_sts_t sts;

  logic               in_ready;
  logic               out_valid;
  logic               cfg_ready;
  logic [INDEX_W-1:0] peak_index;
  logic [SCORE_W-1:0] peak_score;

  // sequencer: handshakes, sweep order, block count, registers
  rap_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_if.valid),
    .in_block_end (in_if.data.block_end),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_if.ready),
    .cfg_valid    (cfg_if.valid),
    .cfg_index    (cfg_if.data.index),
    .cfg_wdata    (cfg_if.data.wdata),
    .cfg_ready    (cfg_ready),
    .cmd          (cmd),
    .sts          (sts)
  );

  // memories and the shared multiply/accumulate/compare pipeline
  rap_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .MIN_LAG       (MIN_LAG),
    .ACORR_LENGTH  (ACORR_LENGTH),
    .RANGE_SIZE    (RANGE_SIZE),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_sample      (in_if.data.sample),
    .out_peak_index (peak_index),
    .out_peak_score (peak_score)
  );

  assign in_if.ready            = in_ready;
  assign cfg_if.ready           = cfg_ready;
  assign out_if.valid           = out_valid;
  assign out_if.data.peak_index = peak_index;
  assign out_if.data.peak_score = peak_score;

endmodule

`default_nettype wire
